/* design/e2ec_pkg.sv */
// Shared types, constants and CRC function for the E2E protect/check block.
`default_nettype none
package e2ec_pkg;

  localparam int unsigned SlotCount     = 16;
  localparam int unsigned SlotW         = 4;
  localparam int unsigned MaxFrameBytes = 8;
  localparam int unsigned FrameW        = 8 * MaxFrameBytes;
  localparam int unsigned ByteIdxW      = 3;
  localparam logic [7:0]  CrcPoly       = 8'h1D;
  localparam logic [7:0]  FailLimit     = 8'd3;
  localparam logic [7:0]  FailMax       = 8'hFF;

  typedef enum logic [2:0] {
    CFG_HB_SLOT         = 3'd0,
    CFG_HB_DATA_ID      = 3'd1,
    CFG_CURRENT_SLOT    = 3'd2,
    CFG_CURRENT_DATA_ID = 3'd3,
    CFG_STATUS_SLOT     = 3'd4,
    CFG_STATUS_DATA_ID  = 3'd5,
    CFG_ESTOP_SLOT      = 3'd6,
    CFG_ESTOP_DATA_ID   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BAD   = 2'd1,
    STATUS_CRC   = 2'd2,
    STATUS_ALIVE = 2'd3
  } status_e;

  typedef enum logic {
    OP_PROTECT = 1'b0,
    OP_CHECK   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CRC  = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic last_byte;
  } dp_sts_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] d);
    logic [7:0] c;
    c = d;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* design/e2e_crc8_alive_protect_check.sv */
// Top level of the CRC-8 / alive counter E2E protect and check block.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  opcode, slot, frame_length, frame_in
//   out      source     out_valid_o/out_stall_i frame_out, status, fail_count, safe_default
//   cfg      sink       cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A word goes from accept through the CRC byte steps (frame_length capped at 8) to
// the finish step; a rejected word skips the CRC. The CRC runs one frame byte per cycle.
// The next word is accepted as soon as the previous one is handed to the output
// register; a stalled result holds only the finish step.
// Reset restores config defaults and clears alive counters and failure counts.
`default_nettype none
module e2e_crc8_alive_protect_check (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [7:0]  cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         opcode_i,
  input  wire  [7:0]  slot_i,
  input  wire  [3:0]  frame_length_i,
  input  wire  [63:0] frame_in_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [63:0] frame_out_o,
  output logic [1:0]  status_o,
  output logic [7:0]  fail_count_o,
  output logic        safe_default_o
);
  import e2ec_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  e2ec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  e2ec_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .frame_length_i (frame_length_i),
    .frame_in_i     (frame_in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .frame_out_o    (frame_out_o),
    .status_o       (status_o),
    .fail_count_o   (fail_count_o),
    .safe_default_o (safe_default_o)
  );

endmodule
`default_nettype wire

/* design/e2ec_ctrl.sv */
// Sequencer for load, CRC byte steps and result hand-off.
`default_nettype none
module e2ec_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  e2ec_pkg::dp_sts_t   sts_i,
  output e2ec_pkg::ctl_cmd_t  cmd_o
);
  import e2ec_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_bad ? S_FIN : S_CRC;
        end
      end
      S_CRC: begin
        if (sts_i.last_byte) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_CRC: begin
        cmd_o.step = 1'b1;
      end
      S_FIN: begin
        cmd_o.finish = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("pending result dropped");

  a_load_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q != S_IDLE)
    else $error("load did not start work");

  a_crc_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CRC && !sts_i.last_byte |=> state_q == S_CRC)
    else $error("CRC loop ended early");

  a_finish_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q && state_q == S_IDLE)
    else $error("finish did not present word");

endmodule
`default_nettype wire

/* design/e2ec_dp.sv */
// Datapath: config registers, slot tables, byte-serial CRC and result registers.
`default_nettype none
module e2ec_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [2:0]          cfg_idx_i,
  input  wire  [7:0]          cfg_wdata_i,
  input  wire                 opcode_i,
  input  wire  [7:0]          slot_i,
  input  wire  [3:0]          frame_length_i,
  input  wire  [63:0]         frame_in_i,
  input  e2ec_pkg::ctl_cmd_t  cmd_i,
  output e2ec_pkg::dp_sts_t   sts_o,
  output logic [63:0]         frame_out_o,
  output logic [1:0]          status_o,
  output logic [7:0]          fail_count_o,
  output logic                safe_default_o
);
  import e2ec_pkg::*;

  logic [SlotW-1:0] hb_slot_q, current_slot_q, status_slot_q, estop_slot_q;
  logic [7:0]       hb_id_q, current_id_q, status_id_q, estop_id_q;

  logic [3:0] tx_alive_q [SlotCount];
  logic [3:0] rx_last_q  [SlotCount];
  logic [7:0] fail_q     [SlotCount];

  logic              op_q;
  logic              bad_q;
  logic              slot_ok_q;
  logic [SlotW-1:0]  slot_q;
  logic [ByteIdxW-1:0] last_q;
  logic [ByteIdxW-1:0] idx_q;
  logic [7:0]        crc_q;
  logic [FrameW-1:0] frame_q;

  logic [63:0] frame_out_q;
  logic [1:0]  status_q;
  logic [7:0]  fc_q;
  logic        safe_q;

  logic              in_slot_ok;
  logic [3:0]        len_clamp;
  logic [SlotW-1:0]  in_slot;
  logic [7:0]        seed;
  logic [FrameW-1:0] frame_ld;

  logic [7:0] fc_cur;
  logic [7:0] fc_inc;
  logic [3:0] ra;
  logic       crc_bad;
  logic       alive_bad;
  logic [7:0] fc_new;
  logic [1:0] st_new;
  logic [FrameW-1:0] fo_new;

  assign in_slot_ok = {1'b0, slot_i} < 9'(SlotCount);
  assign len_clamp  = (frame_length_i > 4'(MaxFrameBytes)) ? 4'(MaxFrameBytes)
                                                           : frame_length_i;
  assign in_slot    = slot_i[SlotW-1:0];
  assign sts_o.in_bad    = !in_slot_ok || (len_clamp < 4'd2);
  assign sts_o.last_byte = idx_q == last_q;

  always_comb begin
    seed = 8'h00;
    if (opcode_i == OP_CHECK) begin
      if (in_slot == estop_slot_q) seed = estop_id_q;
    end else if (in_slot == hb_slot_q) begin
      seed = hb_id_q;
    end else if (in_slot == current_slot_q) begin
      seed = current_id_q;
    end else if (in_slot == status_slot_q) begin
      seed = status_id_q;
    end
  end

  always_comb begin
    frame_ld = frame_in_i;
    if (opcode_i == OP_PROTECT && !sts_o.in_bad) begin
      frame_ld[11:8] = tx_alive_q[in_slot];
    end
  end

  always_comb begin
    fc_cur    = slot_ok_q ? fail_q[slot_q] : 8'h00;
    fc_inc    = (fc_cur == FailMax) ? fc_cur : fc_cur + 8'd1;
    ra        = frame_q[11:8];
    crc_bad   = crc_q != frame_q[7:0];
    alive_bad = ra != (rx_last_q[slot_q] + 4'd1);
    fo_new    = frame_q;
    st_new    = STATUS_OK;
    fc_new    = fc_cur;
    if (bad_q) begin
      st_new = STATUS_BAD;
    end else if (op_q == OP_PROTECT) begin
      fo_new[7:0] = crc_q;
    end else if (crc_bad) begin
      st_new = STATUS_CRC;
      fc_new = fc_inc;
    end else if (alive_bad) begin
      st_new = STATUS_ALIVE;
      fc_new = fc_inc;
    end else begin
      fc_new = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_slot_q      <= SlotW'(0);
      current_slot_q <= SlotW'(1);
      status_slot_q  <= SlotW'(2);
      estop_slot_q   <= SlotW'(3);
      hb_id_q        <= 8'h00;
      current_id_q   <= 8'h00;
      status_id_q    <= 8'h00;
      estop_id_q     <= 8'h00;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_HB_SLOT:         hb_slot_q      <= cfg_wdata_i[SlotW-1:0];
        CFG_HB_DATA_ID:      hb_id_q        <= cfg_wdata_i;
        CFG_CURRENT_SLOT:    current_slot_q <= cfg_wdata_i[SlotW-1:0];
        CFG_CURRENT_DATA_ID: current_id_q   <= cfg_wdata_i;
        CFG_STATUS_SLOT:     status_slot_q  <= cfg_wdata_i[SlotW-1:0];
        CFG_STATUS_DATA_ID:  status_id_q    <= cfg_wdata_i;
        CFG_ESTOP_SLOT:      estop_slot_q   <= cfg_wdata_i[SlotW-1:0];
        CFG_ESTOP_DATA_ID:   estop_id_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        tx_alive_q[i] <= 4'h0;
        rx_last_q[i]  <= 4'h0;
        fail_q[i]     <= 8'h00;
      end
    end else if (cmd_i.finish && !bad_q) begin
      if (op_q == OP_PROTECT) begin
        tx_alive_q[slot_q] <= frame_q[11:8] + 4'd1;
      end else begin
        fail_q[slot_q] <= fc_new;
        if (!crc_bad) rx_last_q[slot_q] <= ra;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= opcode_i;
      bad_q     <= sts_o.in_bad;
      slot_ok_q <= in_slot_ok;
      slot_q    <= in_slot;
      last_q    <= ByteIdxW'(len_clamp - 4'd1);
      idx_q     <= ByteIdxW'(1);
      crc_q     <= seed;
      frame_q   <= frame_ld;
    end else if (cmd_i.step) begin
      crc_q <= crc8_byte(crc_q ^ frame_q[8*idx_q +: 8]);
      idx_q <= idx_q + ByteIdxW'(1);
    end
    if (cmd_i.finish) begin
      frame_out_q <= fo_new;
      status_q    <= st_new;
      fc_q        <= fc_new;
      safe_q      <= fc_new >= FailLimit;
    end
  end

  assign frame_out_o    = frame_out_q;
  assign status_o       = status_q;
  assign fail_count_o   = fc_q;
  assign safe_default_o = safe_q;

endmodule
`default_nettype wire
